// ----- hw/rtl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// Fixed field widths of the item and result beats.
	localparam int OP_W     = 2;
	localparam int IDX_W    = 10;
	localparam int LIM_W    = 11;
	localparam int STATUS_W = 2;

	// Defaults of the top-level parameters.
	localparam int SLOTS_DEF     = 1024;
	localparam int WORD_BITS_DEF = 32;

	// Slot limit after reset.
	localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd1024;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_ALLOC = 2'd0;
	localparam op_t OP_FREE  = 2'd1;
	localparam op_t OP_CHECK = 2'd2;
	localparam op_t OP_NOP   = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_RANGE     = 2'd2,
		STAT_NOT_ALLOC = 2'd3
	} status_t;

	// Outcome of searching one bitmap word.
	typedef struct packed {
		logic found;
		logic last;
	} scan_flags_t;

endpackage

// ----- hw/rtl/bsa_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_bitmap_ram
// Single-clock bitmap store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsa_bitmap_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bsa_word_scan.sv -----
// ----------------------------------------------------------------------------
// bsa_word_scan
// Finds the lowest free slot of one bitmap word that lies below the limit.
// ----------------------------------------------------------------------------
module bsa_word_scan #(
	parameter int WORD_BITS = 32,
	localparam int BIT_W = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0]        word,
	input  logic [bsa_pkg::LIM_W-1:0]   base,
	input  logic [bsa_pkg::LIM_W-1:0]   lim,
	output bsa_pkg::scan_flags_t        flags,
	output logic [BIT_W-1:0]            pos,
	output logic [WORD_BITS-1:0]        grant
);
	import bsa_pkg::*;

	localparam int SUM_W = LIM_W + 1;

	logic [WORD_BITS-1:0] eligible;
	logic [SUM_W-1:0]     cand;

	always_comb begin
		cand = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			cand        = {1'b0, base} + SUM_W'(b);
			eligible[b] = !word[b] && (cand < {1'b0, lim});
		end
	end

	// Isolate the lowest eligible bit, then encode its position.
	assign grant = eligible & (~eligible + WORD_BITS'(1));

	always_comb begin
		pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (grant[b]) begin
				pos = pos | BIT_W'(b);
			end
		end
	end

	assign flags.found = |eligible;
	assign flags.last  = ({1'b0, base} + SUM_W'(WORD_BITS)) >= {1'b0, lim};

endmodule

// ----- hw/rtl/bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-fit slot allocator over a bitmap of used slots held in a RAM.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   op, slot_index
//   out      source     out_valid / out_stall status, slot, is_allocated,
//                                             live_count
//   cfg      sink       cfg_valid / cfg_ready cfg_data (slot limit)
//
// Allocate reads one bitmap word per cycle from word 0 up to the word that
// holds the limit, and writes back the word with the lowest free slot set.
// Free and check read the word of the index, free writes it back when the
// bit was set; an index out of range skips the read. The spare code and a
// zero limit answer without a RAM access. After reset the bitmap RAM is
// cleared one word per cycle, during which in_stall stays high.
// A new item is taken while a result beat still waits on out_stall.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
	parameter int SLOTS     = bsa_pkg::SLOTS_DEF,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bsa_pkg::OP_W-1:0]      op,
	input  logic [bsa_pkg::IDX_W-1:0]     slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bsa_pkg::STATUS_W-1:0]  status,
	output logic [bsa_pkg::IDX_W-1:0]     slot,
	output logic                          is_allocated,
	output logic [bsa_pkg::LIM_W-1:0]     live_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsa_pkg::LIM_W-1:0]     cfg_data
);
	import bsa_pkg::*;

	localparam int NUM_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
	localparam int SAT_LIM   = (SLOTS < 2**LIM_W) ? SLOTS : 2**LIM_W - 1;
	localparam int CNT_CAP   = (SAT_LIM < 2**IDX_W) ? SAT_LIM : 2**IDX_W;
	// Quotient by the word size through a reciprocal, exact for any index.
	localparam int QSH       = 17;
	localparam int RECIP     = (2**QSH + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W    = 26;
	localparam int QUOT_W    = PROD_W - QSH;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADDR,
		S_SCAN,
		S_LOOKUP,
		S_RESULT
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [IDX_W-1:0]     idx_q;
	logic [ADDR_W-1:0]    widx_q;
	logic [BIT_W-1:0]     bit_q;
	logic [ADDR_W-1:0]    scan_addr_q;
	logic [LIM_W-1:0]     base_q;
	logic [ADDR_W-1:0]    clr_addr_q;
	logic [LIM_W-1:0]     used_count_q;
	logic [LIM_W-1:0]     slot_limit_q;
	status_t              res_status_q;
	logic [IDX_W-1:0]     res_slot_q;
	logic                 res_alloc_q;
	logic                 out_valid_q;
	status_t              status_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 is_alloc_q;
	logic [LIM_W-1:0]     live_q;

	logic [LIM_W-1:0]     lim;
	logic                 in_acc;
	logic [PROD_W-1:0]    prod;
	logic [QUOT_W-1:0]    quot;
	logic [IDX_W-1:0]     wbase;
	logic [IDX_W-1:0]     rem;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	scan_flags_t          scan_flags;
	logic [BIT_W-1:0]     scan_pos;
	logic [WORD_BITS-1:0] scan_grant;
	logic                 look_bit;

	bsa_bitmap_ram #(
		.DEPTH(NUM_WORDS),
		.WIDTH(WORD_BITS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	bsa_word_scan #(
		.WORD_BITS(WORD_BITS)
	) u_scan (
		.word (mem_rdata),
		.base (base_q),
		.lim  (lim),
		.flags(scan_flags),
		.pos  (scan_pos),
		.grant(scan_grant)
	);

	assign lim    = (slot_limit_q > LIM_W'(SAT_LIM)) ? LIM_W'(SAT_LIM) : slot_limit_q;
	assign in_acc = in_valid && (state_q == S_IDLE);

	assign prod  = PROD_W'(slot_index) * PROD_W'(RECIP);
	assign quot  = prod[PROD_W-1:QSH];
	assign wbase = IDX_W'(int'(widx_q) * WORD_BITS);
	assign rem   = idx_q - wbase;

	assign look_bit = mem_rdata[bit_q];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_addr_q;
		mem_wdata = mem_rdata | scan_grant;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_re = in_acc && (op == OP_ALLOC) && (lim != '0);
			end
			S_ADDR: begin
				mem_re    = idx_q < IDX_W'(lim) || lim > LIM_W'(2**IDX_W - 1);
				mem_raddr = widx_q;
			end
			S_SCAN: begin
				if (scan_flags.found) begin
					mem_we = 1'b1;
				end else if (!scan_flags.last) begin
					mem_re    = 1'b1;
					mem_raddr = scan_addr_q + ADDR_W'(1);
				end
			end
			S_LOOKUP: begin
				if (op_q == OP_FREE && look_bit) begin
					mem_we    = 1'b1;
					mem_waddr = widx_q;
					mem_wdata = mem_rdata & ~(WORD_BITS'(1) << bit_q);
				end
			end
			S_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			op_q         <= OP_ALLOC;
			idx_q        <= '0;
			widx_q       <= '0;
			bit_q        <= '0;
			scan_addr_q  <= '0;
			base_q       <= '0;
			clr_addr_q   <= '0;
			used_count_q <= '0;
			res_status_q <= STAT_OK;
			res_slot_q   <= '0;
			res_alloc_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			status_q     <= STAT_OK;
			slot_q       <= '0;
			is_alloc_q   <= 1'b0;
			live_q       <= '0;
		end else begin
			// In the result state the output register is handled below.
			if (out_valid_q && !out_stall && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						op_q        <= op;
						idx_q       <= slot_index;
						widx_q      <= ADDR_W'(quot);
						scan_addr_q <= '0;
						base_q      <= '0;
						res_alloc_q <= 1'b0;
						unique case (op)
							OP_ALLOC: begin
								if (lim == '0) begin
									res_status_q <= STAT_FULL;
									res_slot_q   <= '0;
									state_q      <= S_RESULT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_FREE, OP_CHECK: begin
								state_q <= S_ADDR;
							end
							default: begin
								res_status_q <= STAT_OK;
								res_slot_q   <= slot_index;
								state_q      <= S_RESULT;
							end
						endcase
					end
				end
				S_ADDR: begin
					bit_q <= BIT_W'(rem);
					if (mem_re) begin
						state_q <= S_LOOKUP;
					end else begin
						res_status_q <= STAT_RANGE;
						res_slot_q   <= idx_q;
						state_q      <= S_RESULT;
					end
				end
				S_SCAN: begin
					if (scan_flags.found) begin
						used_count_q <= used_count_q + LIM_W'(1);
						res_status_q <= STAT_OK;
						res_slot_q   <= IDX_W'(base_q + LIM_W'(scan_pos));
						state_q      <= S_RESULT;
					end else if (scan_flags.last) begin
						res_status_q <= STAT_FULL;
						res_slot_q   <= '0;
						state_q      <= S_RESULT;
					end else begin
						scan_addr_q <= scan_addr_q + ADDR_W'(1);
						base_q      <= base_q + LIM_W'(WORD_BITS);
					end
				end
				S_LOOKUP: begin
					res_slot_q <= idx_q;
					state_q    <= S_RESULT;
					if (op_q == OP_FREE) begin
						if (look_bit) begin
							res_status_q <= STAT_OK;
							if (used_count_q != '0) begin
								used_count_q <= used_count_q - LIM_W'(1);
							end
						end else begin
							res_status_q <= STAT_NOT_ALLOC;
						end
					end else begin
						res_status_q <= STAT_OK;
						res_alloc_q  <= look_bit;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						slot_q      <= res_slot_q;
						is_alloc_q  <= res_alloc_q;
						live_q      <= used_count_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The limit register; the port never holds off a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			slot_limit_q <= cfg_data;
		end
	end

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign is_allocated = is_alloc_q;
	assign live_count   = live_q;

	// The count only moves together with a bitmap write-back.
	a_count_with_write: assert property (@(posedge clk) disable iff (!arst_n)
		(used_count_q != $past(used_count_q)) |-> $past(mem_we))
		else $error("slot count changed without a bitmap write");

	// No write-back may still be under way while new items are taken.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !mem_we)
		else $error("bitmap write while accepting items");

	// A finished result waits while the previous beat is stalled.
	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && out_valid_q && out_stall) |=> (state_q == S_RESULT))
		else $error("result left before the output beat was taken");

	// The scan never starts a word at or beyond the limit.
	a_scan_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (base_q < lim))
		else $error("scan passed the slot limit");

	// No more slots can be in use than there are slots to grant.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= LIM_W'(CNT_CAP))
		else $error("slot count beyond the number of slots");

endmodule

// ----- bench/slot_alloc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_alloc_checker
// Watches the item, result and limit channels of the slot allocator, keeps
// its own copy of the bitmap, count and limit, and compares each result beat
// field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module slot_alloc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [bsa_pkg::OP_W-1:0]     op,
	input  logic [bsa_pkg::IDX_W-1:0]    slot_index,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [bsa_pkg::STATUS_W-1:0] status,
	input  logic [bsa_pkg::IDX_W-1:0]    slot,
	input  logic                         is_allocated,
	input  logic [bsa_pkg::LIM_W-1:0]    live_count,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [bsa_pkg::LIM_W-1:0]    cfg_data,
	output int                           err_count,
	output int                           outstanding
);
	import bsa_pkg::*;

	localparam int SLOT_COUNT = SLOTS_DEF;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] slot;
		logic             is_allocated;
		logic [LIM_W-1:0] live_count;
	} alloc_result_t;

	bit [SLOT_COUNT-1:0] used_map;
	logic [LIM_W-1:0]    in_use;
	logic [LIM_W-1:0]    limit_reg;
	alloc_result_t       pending_results[$];
	alloc_result_t       due;
	int                  mismatches = 0;

	assign err_count = mismatches;

	// Applies one operation to the local bitmap and returns the beat it should give.
	function automatic alloc_result_t apply_slot_op(op_t code, logic [IDX_W-1:0] idx);
		alloc_result_t r;
		int            bound;
		int            s;
		bit            granted;
		bound = (limit_reg > SLOT_COUNT) ? SLOT_COUNT : int'(limit_reg);
		r.status       = STAT_OK;
		r.slot         = idx;
		r.is_allocated = 1'b0;
		granted        = 1'b0;
		case (code)
			OP_ALLOC: begin
				r.status = STAT_FULL;
				r.slot   = '0;
				for (s = 0; s < bound && !granted; s++) begin
					if (!used_map[s]) begin
						used_map[s] = 1'b1;
						in_use      = in_use + 1'b1;
						r.slot      = IDX_W'(s);
						r.status    = STAT_OK;
						granted     = 1'b1;
					end
				end
			end
			OP_FREE: begin
				if (idx >= bound)
					r.status = STAT_RANGE;
				else if (!used_map[idx])
					r.status = STAT_NOT_ALLOC;
				else begin
					used_map[idx] = 1'b0;
					if (in_use != 0)
						in_use = in_use - 1'b1;
				end
			end
			OP_CHECK: begin
				if (idx >= bound)
					r.status = STAT_RANGE;
				else
					r.is_allocated = used_map[idx];
			end
			default: begin
				// The spare code is answered but leaves the state alone.
			end
		endcase
		r.live_count = in_use;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_map  = '0;
			in_use    = '0;
			limit_reg = LIMIT_RESET;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: status %0d, slot %0d",
						status, slot);
					mismatches++;
				end else begin
					due = pending_results.pop_front();
					check_field("status", 16'(due.status), 16'(status));
					check_field("slot", 16'(due.slot), 16'(slot));
					check_field("is_allocated", 16'(due.is_allocated), 16'(is_allocated));
					check_field("live_count", 16'(due.live_count), 16'(live_count));
				end
			end
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			if (in_valid && !in_stall)
				pending_results.push_back(apply_slot_op(op_t'(op), slot_index));
			outstanding <= pending_results.size();
		end
	end

endmodule

// ----- bench/tb_bitmap_slot_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator
// Drives allocate, free and check beats into the slot allocator under a range
// of slot limits and back-pressure patterns; the checker beside the block
// predicts every result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator;
	import bsa_pkg::*;

	// Longest stretch without any beat: clearing pass, slow scans and stalls.
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 40;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	op_t                 op         = OP_ALLOC;
	logic [IDX_W-1:0]    slot_index = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    slot;
	logic                is_allocated;
	logic [LIM_W-1:0]    live_count;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [LIM_W-1:0]    cfg_data   = '0;

	int fail_count;
	int outstanding;
	int gap_pct     = 34;
	int stall_pct   = 74;
	int alloc_reach = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	bitmap_slot_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .slot_index(slot_index),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .slot(slot),
		.is_allocated(is_allocated), .live_count(live_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	slot_alloc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .slot_index(slot_index),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .slot(slot),
		.is_allocated(is_allocated), .live_count(live_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.err_count(fail_count), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Valid stays high from one beat to the next unless a gap is drawn.
	task automatic send_item(op_t code, logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= code;
		slot_index <= idx;
		if (code == OP_ALLOC && alloc_reach < SLOTS_DEF - 1)
			alloc_reach++;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [LIM_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [LIM_W-1:0] lim, int items, int alloc_pct, int free_pct);
		int               eff;
		int               span;
		int               pick;
		op_t              code;
		logic [IDX_W-1:0] idx;
		write_limit(lim);
		eff = (lim > SLOTS_DEF) ? SLOTS_DEF : int'(lim);
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < alloc_pct)
				code = OP_ALLOC;
			else if (pick < alloc_pct + free_pct)
				code = OP_FREE;
			else if (pick < 97)
				code = OP_CHECK;
			else
				code = OP_NOP;
			// First fit keeps used slots low, so most indexes aim below the highest grant.
			span = (alloc_reach < eff + 2) ? alloc_reach : eff + 2;
			if (span > SLOTS_DEF - 1)
				span = SLOTS_DEF - 1;
			if ($urandom_range(9) == 0)
				idx = IDX_W'($urandom_range(SLOTS_DEF - 1));
			else
				idx = IDX_W'($urandom_range(span));
			if ($urandom_range(49) == 0)
				drain_results();
			send_item(code, idx);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Default limit: a fresh bitmap, first-fit grants and freed holes refilled.
		send_item(OP_CHECK, 10'd0);
		send_item(OP_FREE, 10'd0);
		send_item(OP_ALLOC, 10'd0);
		send_item(OP_ALLOC, 10'h3ff);
		send_item(OP_ALLOC, 10'd0);
		send_item(OP_CHECK, 10'd1);
		send_item(OP_FREE, 10'd1);
		send_item(OP_ALLOC, 10'd0);
		send_item(OP_FREE, 10'h3ff);
		send_item(OP_CHECK, 10'h3ff);
		send_item(OP_NOP, 10'h3ff);
		send_item(OP_NOP, 10'h2aa);
		// With no slots available everything is full or out of range.
		write_limit(11'd0);
		send_item(OP_ALLOC, 10'd0);
		send_item(OP_FREE, 10'd0);
		send_item(OP_CHECK, 10'd0);
		// An oversized limit behaves as the full table.
		write_limit(11'h7ff);
		send_item(OP_ALLOC, 10'd0);
		send_item(OP_CHECK, 10'h3ff);
		// Slot 3 is left used above the lowered limit and must stay out of reach.
		write_limit(11'd3);
		send_item(OP_ALLOC, 10'd0);
		send_item(OP_CHECK, 10'd3);
		send_item(OP_FREE, 10'd3);
		write_limit(11'd1);
		send_item(OP_FREE, 10'd0);
		send_item(OP_ALLOC, 10'd0);

		run_phase(11'd40, 150, 60, 25);
		run_phase(LIM_W'($urandom_range(1, SLOTS_DEF)), 80, 50, 30);
		run_phase(11'h7ff, 120, 55, 25);

		gap_pct   = 74;
		stall_pct = 34;
		run_phase(11'd33, 110, 50, 30);
		run_phase(11'd7, 50, 50, 30);
		run_phase(11'd1, 30, 50, 30);
		run_phase(11'd0, 20, 40, 30);

		gap_pct   = 0;
		stall_pct = 0;
		run_phase(11'd1024, 480, 88, 8);
		run_phase(11'd8, 60, 50, 30);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
